// ===== rtl/msb_first_bit_packer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the MSB-first bit packer
// Shared macros for the concurrent checks on the packer's ports.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_TOP_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_TOP_DEFINES_SVH

// A property checked on every rising clock edge outside reset.
`define MBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A property whose consequent is checked in the cycle after its antecedent.
`define MBP_ASSERT_NEXT(label, ante, cons, msg) \
    `MBP_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/mbp_pkg.sv =====
// ----------------------------------------------------------------------------
// MSB-first bit packer package
// Request codes and sizing constants shared by the packer and its checker.
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int BLOCK_BYTES_DEF = 64;
    localparam int BYTE_W          = 8;
    localparam int CODE_W          = 32;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_FLUSH  = 2'd2
    } t_req;

endpackage

// ===== rtl/mbp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/msb_first_bit_packer_top.sv =====
// ----------------------------------------------------------------------------
// MSB-first variable-length bit packer
// An append of n code bits keeps busy high while a single shifter places the
// bytes it touches, one to five of them, into the block RAM at one byte per
// cycle. A zero-length or dropped append and a clear finish in the start
// cycle. A flush of L bytes keeps busy high while the RAM gives one byte per
// cycle and then while the drain state clears the block; the first byte is
// strobed on o_valid from the valid register that the flush state loads. The
// receiver cannot stall: each byte is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_top #(
    parameter int BLOCK_BYTES = mbp_pkg::BLOCK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_code_bits,
    input  logic [5:0]  i_code_length,
    input  logic [6:0]  i_block_length,
    output logic        o_valid,
    output logic [7:0]  o_byte_out,
    output logic        o_last_byte,
    output logic        o_overflowed
);

    localparam int AW = $clog2(BLOCK_BYTES);
    localparam int UW = $clog2(BLOCK_BYTES + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_APPEND = 4'b0010,
        S_FLUSH  = 4'b0100,
        S_DRAIN  = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [UW-1:0]               r_used, n_used;
    logic [2:0]                  r_free, n_free;
    logic                        r_ovf, n_ovf;
    logic [mbp_pkg::CODE_W-1:0]  r_code, n_code;
    logic [5:0]                  r_bits_left, n_bits_left;
    logic [mbp_pkg::BYTE_W-1:0]  r_part, n_part;
    logic [AW-1:0]               r_idx, n_idx;
    logic [AW-1:0]               r_last_idx, n_last_idx;
    logic                        r_p_vld, n_p_vld;
    logic                        r_p_last, n_p_last;
    logic                        r_p_zero, n_p_zero;

    logic                        w_accept;
    logic [5:0]                  w_len_in;
    logic [5:0]                  w_free_ext;
    logic [5:0]                  w_over;
    logic [2:0]                  w_need;
    logic [UW:0]                 w_sum;
    logic                        w_fits;
    logic [6:0]                  w_blk_m1;

    logic                        w_merge;
    logic [3:0]                  w_slot;
    logic [3:0]                  w_take;
    logic [5:0]                  w_amt;
    logic [mbp_pkg::CODE_W+7:0]  w_shifted;
    logic [7:0]                  w_mask;
    logic [7:0]                  w_byte;
    logic [5:0]                  w_bits_rem;
    logic [3:0]                  w_free_rem;
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [7:0]                  w_rdata;

    assign w_accept   = start && !busy;
    assign w_len_in   = (i_code_length > 6'd32) ? 6'd32 : i_code_length;
    assign w_free_ext = {3'b000, r_free};
    assign w_over     = w_len_in - w_free_ext + 6'd7;
    assign w_need     = (w_len_in <= w_free_ext) ? 3'd0 : w_over[5:3];
    assign w_sum      = (UW + 1)'(r_used) + (UW + 1)'(w_need);
    assign w_fits     = (w_sum <= (UW + 1)'(BLOCK_BYTES));

    always_comb begin
        if (i_block_length == 7'd0) begin
            w_blk_m1 = 7'd0;
        end else if (i_block_length > 7'(BLOCK_BYTES)) begin
            w_blk_m1 = 7'(BLOCK_BYTES - 1);
        end else begin
            w_blk_m1 = i_block_length - 7'd1;
        end
    end

    // The shared shifter places the next slice of the code into one byte.
    assign w_merge    = (r_free != 3'd0) && (r_used != '0);
    assign w_slot     = w_merge ? {1'b0, r_free} : 4'd8;
    assign w_take     = (r_bits_left < {2'b00, w_slot}) ? r_bits_left[3:0] : w_slot;
    assign w_amt      = r_bits_left + 6'd8 - {2'b00, w_slot};
    assign w_shifted  = {r_code, 8'h00} >> w_amt;
    assign w_mask     = 8'hFF >> (4'd8 - w_slot);
    assign w_byte     = (w_shifted[7:0] & w_mask) | (w_merge ? r_part : 8'h00);
    assign w_bits_rem = r_bits_left - {2'b00, w_take};
    assign w_free_rem = w_slot - w_take;
    assign w_we       = (r_state == S_APPEND);
    assign w_waddr    = w_merge ? AW'(r_used - UW'(1)) : AW'(r_used);

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_free      = r_free;
        n_ovf       = r_ovf;
        n_code      = r_code;
        n_bits_left = r_bits_left;
        n_part      = r_part;
        n_idx       = r_idx;
        n_last_idx  = r_last_idx;
        n_p_vld     = 1'b0;
        n_p_last    = r_p_last;
        n_p_zero    = r_p_zero;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (mbp_pkg::t_req'(i_req_type))
                        mbp_pkg::REQ_APPEND: begin
                            if (w_len_in != 6'd0) begin
                                if (!w_fits) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_code      = i_code_bits;
                                    n_bits_left = w_len_in;
                                    n_state     = S_APPEND;
                                end
                            end
                        end
                        mbp_pkg::REQ_CLEAR: begin
                            n_used = '0;
                            n_free = 3'd0;
                            n_ovf  = 1'b0;
                        end
                        mbp_pkg::REQ_FLUSH: begin
                            n_idx      = '0;
                            n_last_idx = w_blk_m1[AW-1:0];
                            n_state    = S_FLUSH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_APPEND: begin
                n_bits_left = w_bits_rem;
                n_free      = w_free_rem[2:0];
                n_part      = w_byte;
                if (!w_merge) begin
                    n_used = r_used + UW'(1);
                end
                if (w_bits_rem == 6'd0) begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                n_p_vld  = 1'b1;
                n_p_last = (r_idx == r_last_idx);
                n_p_zero = (UW'(r_idx) >= r_used);
                n_idx    = r_idx + AW'(1);
                if (r_idx == r_last_idx) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_used  = '0;
                n_free  = 3'd0;
                n_ovf   = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_free  <= 3'd0;
            r_ovf   <= 1'b0;
            r_p_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_free  <= n_free;
            r_ovf   <= n_ovf;
            r_p_vld <= n_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code      <= n_code;
        r_bits_left <= n_bits_left;
        r_part      <= n_part;
        r_idx       <= n_idx;
        r_last_idx  <= n_last_idx;
        r_p_last    <= n_p_last;
        r_p_zero    <= n_p_zero;
    end

    mbp_ram #(
        .WIDTH (mbp_pkg::BYTE_W),
        .DEPTH (BLOCK_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_byte),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_p_vld;
    assign o_byte_out   = r_p_zero ? 8'h00 : w_rdata;
    assign o_last_byte  = r_p_last;
    assign o_overflowed = r_ovf;

endmodule

// ===== rtl/mbp_checker.sv =====
// ----------------------------------------------------------------------------
// MSB-first bit packer port checker
// Checks the timing of flushed beats, and that appends show none, against the command handshake.
// ----------------------------------------------------------------------------
`include "msb_first_bit_packer_top_defines.svh"

module mbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_req_type,
    input logic        o_valid,
    input logic        o_last_byte,
    input logic        o_overflowed
);

    `MBP_ASSERT(a_valid_while_busy, o_valid |-> busy, "Beat shown while the packer is idle.")
    `MBP_ASSERT_NEXT(a_append_silent, start && !busy && i_req_type == mbp_pkg::REQ_APPEND, !o_valid, "Append produced a beat.")
    `MBP_ASSERT_NEXT(a_flush_latency, start && !busy && i_req_type == mbp_pkg::REQ_FLUSH, !o_valid ##1 o_valid, "First flush beat not two cycles after start.")
    `MBP_ASSERT_NEXT(a_flush_steady, o_valid && !o_last_byte, o_valid && $stable(o_overflowed), "Flush beats not contiguous or overflow flag changed.")
    `MBP_ASSERT_NEXT(a_flush_end, o_valid && o_last_byte, !o_valid && !busy && !o_overflowed, "Block not cleared after the last beat.")

endmodule

bind msb_first_bit_packer_top mbp_checker u_mbp_checker (.*);
